// File: hdl/ang_pkg.sv
// ----------------------------------------------------------------------------
// ang_pkg
// Shared types and constants of the audio noise gate: register map,
// configuration record, item kinds and fixed arithmetic widths.
// ----------------------------------------------------------------------------
package ang_pkg;

	// Register indexes on the configuration port.
	typedef enum logic [2:0] {
		REG_THR_BASE   = 3'd0,
		REG_THR_DEPTH  = 3'd1,
		REG_ATTACK_LEN = 3'd2,
		REG_ENV_KEEP   = 3'd3,
		REG_ENV_TAKE   = 3'd4
	} reg_index_t;

	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS  = 17;

	// Item kinds.
	localparam logic KIND_SAMPLE = 1'b0;
	localparam logic KIND_TABLE  = 1'b1;

	// Fixed field and datapath widths.
	localparam int COEF_BITS   = 16;
	localparam int ATTACK_BITS = 11;
	localparam int MOD_BITS    = 16;
	localparam int IDX_BITS    = 10;
	localparam int GAIN_BITS   = 16;
	localparam int ENV_BITS    = 24;
	localparam int ENV_FRAC    = 8;
	localparam int Q_FRAC      = 15;
	localparam int TAKE_BITS   = COEF_BITS + ENV_BITS;
	localparam int RHS_BITS    = 35;

	localparam logic [ENV_BITS-1:0] ENV_MAX = '1;

	// Reset values of the registers.
	localparam logic [ATTACK_BITS-1:0] ATTACK_RESET = 11'd44;
	localparam logic [COEF_BITS-1:0]   KEEP_RESET   = 16'd32440;
	localparam logic [COEF_BITS-1:0]   TAKE_RESET   = 16'd328;

	// Depths of the queue between front and back and of the result queue.
	localparam int MID_DEPTH = 4;
	localparam int RES_DEPTH = 8;

	typedef struct packed {
		logic        [COEF_BITS-1:0]   threshold_base;
		logic signed [CFG_DATA_BITS-1:0] threshold_depth;
		logic        [ATTACK_BITS-1:0] attack_len;
		logic        [COEF_BITS-1:0]   env_keep;
		logic        [COEF_BITS-1:0]   env_take;
	} cfg_t;

endpackage

// File: hdl/ang_fifo.sv
// ----------------------------------------------------------------------------
// ang_fifo
// Small synchronous queue on flip-flops, used between front and back and
// for the results.
// ----------------------------------------------------------------------------
module ang_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);

	localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_BITS = $clog2(DEPTH + 1);

	logic [WIDTH-1:0]    store_q [DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q;
	logic [PTR_BITS-1:0] rd_ptr_q;
	logic [CNT_BITS-1:0] count_q;
	logic                do_push;
	logic                do_pop;

	assign full    = (count_q == CNT_BITS'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_data = store_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			store_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			count_q <= count_q + CNT_BITS'(do_push) - CNT_BITS'(do_pop);
		end
	end

endmodule

// File: hdl/ang_front.sv
// ----------------------------------------------------------------------------
// ang_front
// Accepts items, classifies them and prepares the operands that do not
// depend on the envelope: magnitude, the decay term of the magnitude and
// the modulated threshold.
// ----------------------------------------------------------------------------
module ang_front #(
	parameter int SAMPLE_BITS = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  ang_pkg::cfg_t                         cfg,
	input  logic                                  push,
	output logic                                  full,
	input  logic                                  kind,
	input  logic signed [SAMPLE_BITS-1:0]         in_sample,
	input  logic [ang_pkg::MOD_BITS-1:0]          mod_value,
	input  logic [ang_pkg::IDX_BITS-1:0]          table_index,
	input  logic [ang_pkg::GAIN_BITS-1:0]         table_gain,
	input  logic                                  q_full,
	output logic                                  q_push,
	output logic                                  q_kind,
	output logic signed [SAMPLE_BITS-1:0]         q_sample,
	output logic [ang_pkg::ENV_BITS-1:0]          q_amp,
	output logic [ang_pkg::TAKE_BITS-1:0]         q_take_amp,
	output logic signed [ang_pkg::RHS_BITS-1:0]   q_rhs,
	output logic [ang_pkg::IDX_BITS-1:0]          q_index,
	output logic [ang_pkg::GAIN_BITS-1:0]         q_gain
);

	localparam int DM_BITS = ang_pkg::CFG_DATA_BITS + ang_pkg::MOD_BITS + 1;

	logic                               valid_s1;
	logic                               kind_s1;
	logic signed [SAMPLE_BITS-1:0]      sample_s1;
	logic [ang_pkg::MOD_BITS-1:0]       mod_s1;
	logic [ang_pkg::IDX_BITS-1:0]       index_s1;
	logic [ang_pkg::GAIN_BITS-1:0]      gain_s1;

	logic                               accept;
	logic [SAMPLE_BITS-1:0]             raw;
	logic [SAMPLE_BITS-1:0]             mag;
	logic [31:0]                        amp_wide;
	logic signed [ang_pkg::CFG_DATA_BITS-1:0] depth_v;
	logic signed [ang_pkg::MOD_BITS:0]  mod_sx;
	logic signed [DM_BITS-1:0]          depth_mod;
	logic signed [ang_pkg::RHS_BITS-1:0] base_term;

	assign full   = valid_s1 && q_full;
	assign accept = push && !full;
	assign q_push = valid_s1 && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (q_push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1   <= kind;
			sample_s1 <= in_sample;
			mod_s1    <= mod_value;
			index_s1  <= table_index;
			gain_s1   <= table_gain;
		end
	end

	// Magnitude with eight fraction bits, saturated to the envelope range.
	assign raw      = sample_s1;
	assign mag      = raw[SAMPLE_BITS-1] ? (~raw + 1'b1) : raw;
	assign amp_wide = 32'(mag) << ang_pkg::ENV_FRAC;
	assign q_amp    = (amp_wide > 32'(ang_pkg::ENV_MAX)) ? ang_pkg::ENV_MAX
		: amp_wide[ang_pkg::ENV_BITS-1:0];

	assign q_take_amp = ang_pkg::TAKE_BITS'(cfg.env_take) * ang_pkg::TAKE_BITS'(q_amp);

	// Threshold scaled by 2^15 so that the comparison stays exact.
	assign depth_v   = cfg.threshold_depth;
	assign mod_sx    = $signed({1'b0, mod_s1});
	assign depth_mod = depth_v * mod_sx;
	assign base_term = $signed({4'b0, cfg.threshold_base, {ang_pkg::Q_FRAC{1'b0}}});
	assign q_rhs     = base_term + ang_pkg::RHS_BITS'(depth_mod);

	assign q_kind   = kind_s1;
	assign q_sample = sample_s1;
	assign q_index  = index_s1;
	assign q_gain   = gain_s1;

endmodule

// File: hdl/ang_back.sv
// ----------------------------------------------------------------------------
// ang_back
// Carries items out: envelope recurrence, threshold compare, fade position,
// gain table and the gain multiply. Reserves a result slot for every sample
// it takes, so that the pipeline never has to stall.
// ----------------------------------------------------------------------------
module ang_back #(
	parameter int SAMPLE_BITS = 16,
	parameter int FADE_DEPTH  = 1024
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  ang_pkg::cfg_t                         cfg,
	input  logic                                  q_empty,
	output logic                                  q_pop,
	input  logic                                  q_kind,
	input  logic signed [SAMPLE_BITS-1:0]         q_sample,
	input  logic [ang_pkg::ENV_BITS-1:0]          q_amp,
	input  logic [ang_pkg::TAKE_BITS-1:0]         q_take_amp,
	input  logic signed [ang_pkg::RHS_BITS-1:0]   q_rhs,
	input  logic [ang_pkg::IDX_BITS-1:0]          q_index,
	input  logic [ang_pkg::GAIN_BITS-1:0]         q_gain,
	input  logic                                  res_taken,
	output logic                                  res_push,
	output logic signed [SAMPLE_BITS-1:0]         res_sample,
	output logic [ang_pkg::ENV_BITS-1:0]          res_envelope,
	output logic                                  res_closed
);

	localparam int POS_BITS  = $clog2(FADE_DEPTH);
	localparam int CNT_BITS  = $clog2(ang_pkg::RES_DEPTH + 1);
	localparam int ENV_B     = ang_pkg::ENV_BITS;
	localparam int SUM_BITS  = ang_pkg::TAKE_BITS + 1;
	localparam int PROD_W    = SAMPLE_BITS + ang_pkg::GAIN_BITS + 1;
	localparam int QUO_W     = PROD_W - ang_pkg::Q_FRAC;
	localparam int RESET_POS = (int'(ang_pkg::ATTACK_RESET) - 1 > FADE_DEPTH - 1)
		? FADE_DEPTH - 1 : int'(ang_pkg::ATTACK_RESET) - 1;

	logic [CNT_BITS-1:0]                 credit_q;

	logic                                valid_s2;
	logic                                kind_s2;
	logic signed [SAMPLE_BITS-1:0]       sample_s2;
	logic [ENV_B-1:0]                    amp_s2;
	logic [ang_pkg::TAKE_BITS-1:0]       take_amp_s2;
	logic signed [ang_pkg::RHS_BITS-1:0] rhs_s2;
	logic [ang_pkg::IDX_BITS-1:0]        index_s2;
	logic [ang_pkg::GAIN_BITS-1:0]       gain_s2;

	logic [ENV_B-1:0]                    env_q;
	logic [ang_pkg::TAKE_BITS-1:0]       keep_prod;
	logic [SUM_BITS-1:0]                 dec_sum;
	logic [SUM_BITS-ang_pkg::Q_FRAC-1:0] dec_shift;
	logic [ENV_B-1:0]                    env_dec;
	logic [ENV_B-1:0]                    env_next;
	logic                                upd_s2;

	logic                                valid_s3;
	logic                                kind_s3;
	logic signed [SAMPLE_BITS-1:0]       sample_s3;
	logic [ENV_B-1:0]                    env_s3;
	logic signed [ang_pkg::RHS_BITS-1:0] rhs_s3;
	logic [ang_pkg::IDX_BITS-1:0]        index_s3;
	logic [ang_pkg::GAIN_BITS-1:0]       gain_s3;

	logic                                fading_q;
	logic [POS_BITS-1:0]                 fade_pos_q;
	logic [ang_pkg::ATTACK_BITS-1:0]     attack_m1;
	logic [POS_BITS-1:0]                 fade_start;
	logic [POS_BITS-1:0]                 pos;
	logic signed [ang_pkg::RHS_BITS-1:0] lhs_s3;
	logic                                sample_at_s3;
	logic                                below_s3;
	logic                                mem_re;
	logic                                mem_we;

	logic [ang_pkg::GAIN_BITS-1:0]       gain_mem [FADE_DEPTH];

	logic                                valid_s4;
	logic signed [SAMPLE_BITS-1:0]       sample_s4;
	logic [ENV_B-1:0]                    env_s4;
	logic                                closed_s4;
	logic [ang_pkg::GAIN_BITS-1:0]       gain_s4;

	logic signed [ang_pkg::GAIN_BITS:0]  gain_sx;
	logic signed [PROD_W-1:0]            prod;
	logic signed [PROD_W-1:0]            biased;
	logic [QUO_W-1:0]                    quo;
	logic [SAMPLE_BITS-1:0]              sat;

	// A sample is only taken while a result slot is free for it.
	assign q_pop = !q_empty && (credit_q < CNT_BITS'(ang_pkg::RES_DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			credit_q <= '0;
		end else begin
			credit_q <= credit_q + CNT_BITS'(q_pop && (q_kind == ang_pkg::KIND_SAMPLE))
				- CNT_BITS'(res_taken);
		end
	end

	// Stage 2: envelope recurrence, one update per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= q_pop;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			kind_s2     <= q_kind;
			sample_s2   <= q_sample;
			amp_s2      <= q_amp;
			take_amp_s2 <= q_take_amp;
			rhs_s2      <= q_rhs;
			index_s2    <= q_index;
			gain_s2     <= q_gain;
		end
	end

	assign upd_s2    = valid_s2 && (kind_s2 == ang_pkg::KIND_SAMPLE);
	assign keep_prod = ang_pkg::TAKE_BITS'(cfg.env_keep) * ang_pkg::TAKE_BITS'(env_q);
	assign dec_sum   = SUM_BITS'(keep_prod) + SUM_BITS'(take_amp_s2);
	assign dec_shift = dec_sum[SUM_BITS-1:ang_pkg::Q_FRAC];
	assign env_dec   = (dec_shift[SUM_BITS-ang_pkg::Q_FRAC-1:ENV_B] != '0)
		? ang_pkg::ENV_MAX : dec_shift[ENV_B-1:0];
	assign env_next  = (amp_s2 > env_q) ? amp_s2 : env_dec;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			env_q <= '0;
		end else if (upd_s2) begin
			env_q <= env_next;
		end
	end

	// Stage 3: threshold compare, fade position and gain table access.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2) begin
			kind_s3   <= kind_s2;
			sample_s3 <= sample_s2;
			env_s3    <= env_next;
			rhs_s3    <= rhs_s2;
			index_s3  <= index_s2;
			gain_s3   <= gain_s2;
		end
	end

	assign attack_m1  = cfg.attack_len - 1'b1;
	assign fade_start = (cfg.attack_len == '0) ? '0
		: (32'(attack_m1) > 32'(FADE_DEPTH - 1)) ? POS_BITS'(FADE_DEPTH - 1)
		: POS_BITS'(attack_m1);
	assign pos        = fading_q ? fade_pos_q : fade_start;

	assign lhs_s3       = $signed({4'b0, env_s3, 7'b0});
	assign sample_at_s3 = valid_s3 && (kind_s3 == ang_pkg::KIND_SAMPLE);
	assign below_s3     = lhs_s3 < rhs_s3;
	assign mem_re       = sample_at_s3 && below_s3;
	assign mem_we       = valid_s3 && (kind_s3 == ang_pkg::KIND_TABLE)
		&& (32'(index_s3) < 32'(FADE_DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fading_q   <= 1'b0;
			fade_pos_q <= POS_BITS'(RESET_POS);
		end else if (sample_at_s3) begin
			if (below_s3) begin
				fading_q   <= 1'b1;
				fade_pos_q <= (pos == '0) ? '0 : pos - 1'b1;
			end else begin
				fading_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			gain_mem[POS_BITS'(index_s3)] <= gain_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_re) begin
			gain_s4 <= gain_mem[pos];
		end
	end

	// Stage 4: gain multiply, truncation toward zero and saturation.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else begin
			valid_s4 <= sample_at_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_at_s3) begin
			sample_s4 <= sample_s3;
			env_s4    <= env_s3;
			closed_s4 <= below_s3;
		end
	end

	assign gain_sx = $signed({1'b0, gain_s4});
	assign prod    = sample_s4 * gain_sx;
	// Adding 2^15-1 to a negative product makes the shift round toward zero.
	assign biased  = prod + (prod[PROD_W-1] ? PROD_W'((1 << ang_pkg::Q_FRAC) - 1) : '0);
	assign quo     = biased[PROD_W-1:ang_pkg::Q_FRAC];

	always_comb begin
		if ((quo[QUO_W-1:SAMPLE_BITS-1] == '0) || (quo[QUO_W-1:SAMPLE_BITS-1] == '1)) begin
			sat = quo[SAMPLE_BITS-1:0];
		end else if (quo[QUO_W-1]) begin
			sat = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
		end else begin
			sat = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
		end
	end

	assign res_push     = valid_s4;
	assign res_sample   = closed_s4 ? $signed(sat) : sample_s4;
	assign res_envelope = env_s4;
	assign res_closed   = closed_s4;

	a_credit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		credit_q <= CNT_BITS'(ang_pkg::RES_DEPTH))
		else $error("result credit count exceeds the result queue depth");

	a_table_port: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_we && mem_re))
		else $error("gain table written and read in the same cycle");

	a_fade_down: assert property (@(posedge clk) disable iff (!arst_n)
		(sample_at_s3 && below_s3 && fading_q) |=> (fade_pos_q <= $past(fade_pos_q)))
		else $error("fade position moved upwards during a fade");

endmodule

// File: hdl/audio_noise_gate.sv
// ----------------------------------------------------------------------------
// audio_noise_gate
// Noise gate with an envelope follower and a table-driven fade.
// ----------------------------------------------------------------------------
//  Channel   Handshake              Payload
//  input     push / full            kind, in_sample, mod_value, table_index,
//                                   table_gain
//  result    pop / empty            out_sample, envelope_level, gate_closed
//  config    cfg_valid / cfg_ready  cfg_index, cfg_data (ready always high)
//
//  One item is taken per cycle unless full; a sample's result passes stage 1,
//  the middle queue, stages 2 to 4 and the result queue. The rate is set by
//  the back-end envelope recurrence, one 16x24 multiply and add per cycle.
//  Table writes give no result. Reset loads the register defaults; the gain
//  table is not cleared and needs no clearing pass.
//  A stalled result side fills the result queue, then the middle queue,
//  and only then raises full.
// ----------------------------------------------------------------------------
module audio_noise_gate #(
	parameter int FADE_DEPTH  = 1024,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [ang_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
	input  logic [ang_pkg::CFG_DATA_BITS-1:0]     cfg_data,
	input  logic                                  push,
	output logic                                  full,
	input  logic                                  kind,
	input  logic signed [SAMPLE_BITS-1:0]         in_sample,
	input  logic [ang_pkg::MOD_BITS-1:0]          mod_value,
	input  logic [ang_pkg::IDX_BITS-1:0]          table_index,
	input  logic [ang_pkg::GAIN_BITS-1:0]         table_gain,
	output logic                                  empty,
	input  logic                                  pop,
	output logic signed [SAMPLE_BITS-1:0]         out_sample,
	output logic [ang_pkg::ENV_BITS-1:0]          envelope_level,
	output logic                                  gate_closed
);

	localparam int MID_W = 1 + SAMPLE_BITS + ang_pkg::ENV_BITS + ang_pkg::TAKE_BITS
		+ ang_pkg::RHS_BITS + ang_pkg::IDX_BITS + ang_pkg::GAIN_BITS;
	localparam int RES_W = SAMPLE_BITS + ang_pkg::ENV_BITS + 1;

	ang_pkg::cfg_t                       cfg_q;

	logic                                mid_push;
	logic                                mid_full;
	logic                                mid_pop;
	logic                                mid_empty;
	logic [MID_W-1:0]                    mid_wdata;
	logic [MID_W-1:0]                    mid_rdata;

	logic                                f_kind;
	logic signed [SAMPLE_BITS-1:0]       f_sample;
	logic [ang_pkg::ENV_BITS-1:0]        f_amp;
	logic [ang_pkg::TAKE_BITS-1:0]       f_take_amp;
	logic signed [ang_pkg::RHS_BITS-1:0] f_rhs;
	logic [ang_pkg::IDX_BITS-1:0]        f_index;
	logic [ang_pkg::GAIN_BITS-1:0]       f_gain;

	logic                                b_kind;
	logic signed [SAMPLE_BITS-1:0]       b_sample;
	logic [ang_pkg::ENV_BITS-1:0]        b_amp;
	logic [ang_pkg::TAKE_BITS-1:0]       b_take_amp;
	logic signed [ang_pkg::RHS_BITS-1:0] b_rhs;
	logic [ang_pkg::IDX_BITS-1:0]        b_index;
	logic [ang_pkg::GAIN_BITS-1:0]       b_gain;

	logic                                res_push;
	logic                                res_full;
	logic                                res_taken;
	logic signed [SAMPLE_BITS-1:0]       res_sample;
	logic [ang_pkg::ENV_BITS-1:0]        res_envelope;
	logic                                res_closed;
	logic [RES_W-1:0]                    res_wdata;
	logic [RES_W-1:0]                    res_rdata;

	// Configuration registers; writes must arrive only while the block is idle (not enforced).
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.threshold_base  <= '0;
			cfg_q.threshold_depth <= '0;
			cfg_q.attack_len      <= ang_pkg::ATTACK_RESET;
			cfg_q.env_keep        <= ang_pkg::KEEP_RESET;
			cfg_q.env_take        <= ang_pkg::TAKE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				ang_pkg::REG_THR_BASE: begin
					cfg_q.threshold_base <= cfg_data[ang_pkg::COEF_BITS-1:0];
				end
				ang_pkg::REG_THR_DEPTH: begin
					cfg_q.threshold_depth <= $signed(cfg_data);
				end
				ang_pkg::REG_ATTACK_LEN: begin
					cfg_q.attack_len <= cfg_data[ang_pkg::ATTACK_BITS-1:0];
				end
				ang_pkg::REG_ENV_KEEP: begin
					cfg_q.env_keep <= cfg_data[ang_pkg::COEF_BITS-1:0];
				end
				ang_pkg::REG_ENV_TAKE: begin
					cfg_q.env_take <= cfg_data[ang_pkg::COEF_BITS-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	ang_front #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.push        (push),
		.full        (full),
		.kind        (kind),
		.in_sample   (in_sample),
		.mod_value   (mod_value),
		.table_index (table_index),
		.table_gain  (table_gain),
		.q_full      (mid_full),
		.q_push      (mid_push),
		.q_kind      (f_kind),
		.q_sample    (f_sample),
		.q_amp       (f_amp),
		.q_take_amp  (f_take_amp),
		.q_rhs       (f_rhs),
		.q_index     (f_index),
		.q_gain      (f_gain)
	);

	assign mid_wdata = {f_kind, f_sample, f_amp, f_take_amp, f_rhs, f_index, f_gain};

	ang_fifo #(
		.WIDTH (MID_W),
		.DEPTH (ang_pkg::MID_DEPTH)
	) u_mid_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (mid_push),
		.wr_data (mid_wdata),
		.full    (mid_full),
		.pop     (mid_pop),
		.rd_data (mid_rdata),
		.empty   (mid_empty)
	);

	assign {b_kind, b_sample, b_amp, b_take_amp, b_rhs, b_index, b_gain} = mid_rdata;

	ang_back #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.FADE_DEPTH  (FADE_DEPTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.q_empty      (mid_empty),
		.q_pop        (mid_pop),
		.q_kind       (b_kind),
		.q_sample     (b_sample),
		.q_amp        (b_amp),
		.q_take_amp   (b_take_amp),
		.q_rhs        (b_rhs),
		.q_index      (b_index),
		.q_gain       (b_gain),
		.res_taken    (res_taken),
		.res_push     (res_push),
		.res_sample   (res_sample),
		.res_envelope (res_envelope),
		.res_closed   (res_closed)
	);

	assign res_wdata = {res_sample, res_envelope, res_closed};
	assign res_taken = pop && !empty;

	ang_fifo #(
		.WIDTH (RES_W),
		.DEPTH (ang_pkg::RES_DEPTH)
	) u_res_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (res_push),
		.wr_data (res_wdata),
		.full    (res_full),
		.pop     (pop),
		.rd_data (res_rdata),
		.empty   (empty)
	);

	assign {out_sample, envelope_level, gate_closed} = res_rdata;

	a_res_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(res_push && res_full))
		else $error("result dropped: result queue full on push");

	a_mid_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(mid_push && mid_full))
		else $error("item dropped: middle queue full on push");

endmodule
